>>> hdl/rf_pkg.sv
`default_nettype none

package rf_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int COEF_BITS    = 18;
   localparam int STATE_BITS   = 40;
   localparam int OUT_BITS     = 32;
   localparam int OPND_BITS    = STATE_BITS + 1;
   localparam int ACC_BITS     = COEF_BITS + OPND_BITS;
   localparam int NUM_REGS     = 6;
   localparam int REG_IDX_BITS = 3;

   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [STATE_BITS-1:0] state_val_type;
   typedef logic signed [OPND_BITS-1:0]  opnd_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [OUT_BITS-1:0]   out_type;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_HP_GAIN    = 3'd0,
      REG_HP_FB_ONE  = 3'd1,
      REG_HP_FB_TWO  = 3'd2,
      REG_SM_GAIN    = 3'd3,
      REG_SM_FB_ONE  = 3'd4,
      REG_SM_FB_TWO  = 3'd5
   } reg_idx_type;

   localparam coef_type COEF_RESET [NUM_REGS] = '{
      18'sd59864, 18'sd119470, 18'sd54448, 18'sd16589, 18'sd75901, -18'sd26954
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M4,
      ST_M5,
      ST_SUM,
      ST_M3,
      ST_ACC,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_FRAC,
      SH_HALF
   } shift_type;

   typedef struct packed {
      acc_op_type acc_op;
      shift_type  shift;
   } mac_ctrl_type;

   // clamp the accumulator to the stored state width
   function automatic state_val_type sat_state(input acc_type v);
      state_val_type r;
      if (&v[ACC_BITS-1:STATE_BITS-1] || ~|v[ACC_BITS-1:STATE_BITS-1]) begin
         r = v[STATE_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         r = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // clamp a state value to the output width
   function automatic out_type sat_out(input state_val_type v);
      out_type r;
      if (&v[STATE_BITS-1:OUT_BITS-1] || ~|v[STATE_BITS-1:OUT_BITS-1]) begin
         r = v[OUT_BITS-1:0];
      end else if (v[STATE_BITS-1]) begin
         r = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(OUT_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/rf_if.sv
`default_nettype none

interface rf_req_if #(
   parameter int SAMPLE_BITS = rf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] price_sample;

   modport source (output valid, output price_sample, input ready);
   modport sink   (input valid, input price_sample, output ready);
endinterface

interface rf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rf_pkg::OUT_BITS-1:0] roof_value;

   modport source (output valid, output roof_value, input ready);
   modport sink   (input valid, input roof_value, output ready);
endinterface

`default_nettype wire

>>> hdl/roofing_filter.sv
`default_nettype none

// Roofing filter: each price item on req_if passes a two-pole high-pass stage
// and then a two-pole smoother, and gives exactly one Q16 value on rsp_if,
// saturated to 32 bits. The six products per item run one after another
// through a single 18 x 41 multiplier with a registered product and a shared
// accumulator. req_if.ready is high only when no item is in work, so an
// item is taken only after the previous one is committed. The result sits
// in an output register, so the next item is taken even while the previous
// result waits. The six Q16 coefficients must be written through the csr_
// port only while the block is idle; the block itself does not enforce
// this. A write to an index above 5 is ignored. Reset restores the default
// coefficients and clears all history at once; no clearing pass is needed.
module roofing_filter #(
   parameter int SAMPLE_BITS = rf_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = rf_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   rf_req_if.sink                            req_if,
   rf_rsp_if.source                          rsp_if,
   input  logic                              csr_we,
   input  logic [rf_pkg::REG_IDX_BITS-1:0]   csr_index,
   input  logic [rf_pkg::COEF_BITS-1:0]      csr_wdata
);
   import rf_pkg::*;

   localparam int D_BITS = SAMPLE_BITS + 2;

   seq_state_type state_ff, state_in;
   coef_type      coef_ff [NUM_REGS];

   // price history and second difference
   logic signed [SAMPLE_BITS-1:0] price_ff, pp_ff, pp2_ff;
   logic signed [D_BITS-1:0]      d_ff, d_in;

   // high-pass and smoother history
   state_val_type hp1_ff, hp2_ff, f1_ff, f2_ff;
   state_val_type hp_ff;
   opnd_type      sum_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   out_type       rsp_roof_ff;

   mac_ctrl_type  mac_ctrl;
   coef_type      mac_coef;
   opnd_type      mac_opnd;
   acc_type       mac_acc;

   logic          accept, out_free;
   logic          hp_load, sum_load, commit;
   state_val_type filt;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign d_in = D_BITS'(req_if.price_sample) - (D_BITS'(pp_ff) <<< 1) + D_BITS'(pp2_ff);
   assign filt = sat_state(mac_acc);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HP_GAIN:   coef_ff[REG_HP_GAIN]   <= csr_wdata;
            REG_HP_FB_ONE: coef_ff[REG_HP_FB_ONE] <= csr_wdata;
            REG_HP_FB_TWO: coef_ff[REG_HP_FB_TWO] <= csr_wdata;
            REG_SM_GAIN:   coef_ff[REG_SM_GAIN]   <= csr_wdata;
            REG_SM_FB_ONE: coef_ff[REG_SM_FB_ONE] <= csr_wdata;
            REG_SM_FB_TWO: coef_ff[REG_SM_FB_TWO] <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // The smoother feedback products are issued before the one that needs
   // the fresh high-pass value, so the saturate and the pair sum hide
   // behind the multiplier.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mac_ctrl = '{acc_op: ACC_HOLD, shift: SH_NONE};
      mac_coef = '0;
      mac_opnd = '0;
      hp_load  = 1'b0;
      sum_load = 1'b0;
      commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_M0;
         end
         ST_M0: begin
            // input gain on the exact second difference
            mac_coef = coef_ff[REG_HP_GAIN];
            mac_opnd = OPND_BITS'(d_ff);
            state_in = ST_M1;
         end
         ST_M1: begin
            mac_coef = coef_ff[REG_HP_FB_ONE];
            mac_opnd = OPND_BITS'(hp1_ff);
            mac_ctrl = '{acc_op: ACC_LOAD, shift: SH_NONE};
            state_in = ST_M2;
         end
         ST_M2: begin
            mac_coef = coef_ff[REG_HP_FB_TWO];
            mac_opnd = OPND_BITS'(hp2_ff);
            mac_ctrl = '{acc_op: ACC_ADD, shift: SH_FRAC};
            state_in = ST_M4;
         end
         ST_M4: begin
            mac_coef = coef_ff[REG_SM_FB_ONE];
            mac_opnd = OPND_BITS'(f1_ff);
            mac_ctrl = '{acc_op: ACC_SUB, shift: SH_FRAC};
            state_in = ST_M5;
         end
         ST_M5: begin
            // accumulator now holds the raw high-pass sum: clamp and hold it
            mac_coef = coef_ff[REG_SM_FB_TWO];
            mac_opnd = OPND_BITS'(f2_ff);
            mac_ctrl = '{acc_op: ACC_LOAD, shift: SH_FRAC};
            hp_load  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            mac_ctrl = '{acc_op: ACC_ADD, shift: SH_FRAC};
            sum_load = 1'b1;
            state_in = ST_M3;
         end
         ST_M3: begin
            mac_coef = coef_ff[REG_SM_GAIN];
            mac_opnd = sum_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // the extra bit of shift halves the high-pass pair
            mac_ctrl = '{acc_op: ACC_ADD, shift: SH_HALF};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   rf_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .coef  (mac_coef),
      .opnd  (mac_opnd),
      .acc   (mac_acc)
   );

   // ------------------------------------------------------------------
   // working registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         price_ff <= req_if.price_sample;
         d_ff     <= d_in;
      end
      if (hp_load) begin
         hp_ff <= sat_state(mac_acc);
      end
      if (sum_load) begin
         sum_ff <= OPND_BITS'(hp_ff) + OPND_BITS'(hp1_ff);
      end
   end

   // advance the filter history once the result is committed
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff  <= '0;
         pp2_ff <= '0;
         hp1_ff <= '0;
         hp2_ff <= '0;
         f1_ff  <= '0;
         f2_ff  <= '0;
      end else if (commit) begin
         pp2_ff <= pp_ff;
         pp_ff  <= price_ff;
         hp2_ff <= hp1_ff;
         hp1_ff <= hp_ff;
         f2_ff  <= f1_ff;
         f1_ff  <= filt;
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_comb begin
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_roof_ff <= sat_out(filt);
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.roof_value = rsp_roof_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_done_hands_over: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not handed to the output register");

   a_history_holds: assert property (@(posedge clock) disable iff (reset)
      !commit |=> ($stable(pp_ff) && $stable(hp1_ff) && $stable(f1_ff)))
      else $error("filter history moved without a committed item");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside the final step");

endmodule

`default_nettype wire

>>> hdl/rf_mac.sv
`default_nettype none

module rf_mac #(
   parameter int FRAC_BITS = rf_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  rf_pkg::mac_ctrl_type ctrl,
   input  rf_pkg::coef_type     coef,
   input  rf_pkg::opnd_type     opnd,
   output rf_pkg::acc_type      acc
);
   import rf_pkg::*;

   acc_type prod_ff;
   acc_type term;
   acc_type acc_ff;

   // register every product before it reaches the adder
   always_ff @(posedge clock) begin
      prod_ff <= acc_type'(coef) * acc_type'(opnd);
   end

   always_comb begin
      unique case (ctrl.shift)
         SH_NONE: term = prod_ff;
         SH_FRAC: term = prod_ff >>> FRAC_BITS;
         SH_HALF: term = prod_ff >>> (FRAC_BITS + 1);
         default: term = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.acc_op)
         ACC_HOLD: acc_ff <= acc_ff;
         ACC_LOAD: acc_ff <= term;
         ACC_ADD:  acc_ff <= acc_ff + term;
         ACC_SUB:  acc_ff <= acc_ff - term;
         default:  acc_ff <= acc_ff;
      endcase
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

>>> dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rf_pkg::*;

   localparam int SBITS = SAMPLE_BITS_DEF;
   localparam int FRAC  = FRAC_BITS_DEF;

   typedef logic signed [SBITS-1:0] price_type;

   localparam price_type PRICE_MAX = {1'b0, {(SBITS-1){1'b1}}};
   localparam price_type PRICE_MIN = {1'b1, {(SBITS-1){1'b0}}};
   localparam coef_type  COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_type  COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};

   // indexes past the last coefficient; writes there must leave the filter alone
   localparam logic [REG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

   // Cycles to let pass once the last result is in, so the block is certainly idle.
   localparam int SETTLE_CYCLES = 12;

   // Tracks the filter history and the coefficients as the block should hold
   // them, and keeps the roof values that are still owed, oldest first.
   class roof_tracker;
      coef_type gain [NUM_REGS];
      longint   price_q1, price_q2;
      longint   hp_q1, hp_q2;
      longint   sm_q1, sm_q2;
      out_type  roof_due [$];
      int       errors;

      function new();
         foreach (gain[i]) gain[i] = COEF_RESET[i];
         price_q1 = 0;
         price_q2 = 0;
         hp_q1    = 0;
         hp_q2    = 0;
         sm_q1    = 0;
         sm_q2    = 0;
         errors   = 0;
      endfunction

      static function longint clamp_bits(longint v, int bits);
         longint hi, lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void set_coef(logic [REG_IDX_BITS-1:0] idx, coef_type v);
         if (idx < NUM_REGS) gain[idx] = v;
      endfunction

      // Run one price through both stages and queue the value it must give.
      function void note_price(price_type p);
         longint price, d, hp, filt;
         price = longint'(p);
         d     = price - 2 * price_q1 + price_q2;
         hp    = longint'(gain[REG_HP_GAIN]) * d
               + ((longint'(gain[REG_HP_FB_ONE]) * hp_q1) >>> FRAC)
               - ((longint'(gain[REG_HP_FB_TWO]) * hp_q2) >>> FRAC);
         hp    = clamp_bits(hp, STATE_BITS);
         // the extra bit of shift halves the high-pass pair
         filt  = ((longint'(gain[REG_SM_GAIN]) * (hp + hp_q1)) >>> (FRAC + 1))
               + ((longint'(gain[REG_SM_FB_ONE]) * sm_q1) >>> FRAC)
               + ((longint'(gain[REG_SM_FB_TWO]) * sm_q2) >>> FRAC);
         filt  = clamp_bits(filt, STATE_BITS);
         price_q2 = price_q1;
         price_q1 = price;
         hp_q2    = hp_q1;
         hp_q1    = hp;
         sm_q2    = sm_q1;
         sm_q1    = filt;
         roof_due.push_back(out_type'(clamp_bits(filt, OUT_BITS)));
      endfunction

      function void check_roof(out_type got);
         out_type want;
         if (roof_due.size() == 0) begin
            $display("%0t: roof_value %0d arrived with nothing owed", $time, got);
            errors++;
         end else begin
            want = roof_due.pop_front();
            if (got !== want) begin
               $display("%0t: roof_value expected %0d, actual %0d", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int depth();
         return roof_due.size();
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_we;
   logic [REG_IDX_BITS-1:0] csr_index;
   coef_type csr_wdata;

   rf_req_if #(.SAMPLE_BITS(SBITS)) req_bus ();
   rf_rsp_if                        rsp_bus ();

   roof_tracker roofs = new();

   // shared between the sender and the receiver: random gaps on or off, and a
   // one-off long hold-off for the receiver
   bit idle_on     = 1'b1;
   int hold_cycles = 0;

   roofing_filter #(
      .SAMPLE_BITS(SBITS),
      .FRAC_BITS  (FRAC)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Offer one price and hold it until the block takes it. Handshake signals
   // are read just after the edge, so they show what the block saw there.
   task automatic send_price(price_type p);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.price_sample <= p;
      do @(posedge clock); while (!req_bus.ready);
      roofs.note_price(p);
   endtask

   // Write all six coefficients back to back, then one spare index that the
   // block must ignore. Call only while the block is idle.
   task automatic program_coefs(coef_type vals [NUM_REGS]);
      logic [REG_IDX_BITS-1:0] spare;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_idx_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         roofs.set_coef(reg_idx_type'(i), vals[i]);
      end
      spare     = $urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI;
      csr_index <= spare;
      csr_wdata <= coef_type'($urandom);
      @(posedge clock);
      roofs.set_coef(spare, csr_wdata);
      csr_we <= 1'b0;
   endtask

   // Stop offering, wait for every owed value, then let the block settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (roofs.depth() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: random stalls per item, plus the long hold-off when asked.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_cycles > 0) begin
            // hold off long enough for the output register to fill and the
            // block to refuse further prices
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         roofs.check_roof(rsp_bus.roof_value);
      end
   end

   // Stimulus: directed extremes first, then random phases under varied
   // coefficient sets.
   initial begin
      price_type seq [$];
      price_type p;
      coef_type  cset [NUM_REGS];
      int        walk, pick, mode;

      req_bus.valid        <= 1'b0;
      req_bus.price_sample <= '0;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      reset                <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients: full-scale swings, unit steps and a flat run,
      // which the second difference must turn into zero input to the high-pass.
      seq = '{price_type'(0), PRICE_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN,
              price_type'(0), price_type'(1), price_type'(-1),
              price_type'(1000), price_type'(1000), price_type'(1000), PRICE_MAX};
      foreach (seq[i]) send_price(seq[i]);
      drain();

      // Largest coefficients with alternating extremes: drive the high-pass
      // into 40-bit saturation and the output into 32-bit saturation.
      cset = '{default: COEF_MAX};
      program_coefs(cset);
      seq = '{PRICE_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN, PRICE_MAX};
      foreach (seq[i]) send_price(seq[i]);
      drain();

      // Most negative coefficients: saturate towards the other rail.
      cset = '{default: COEF_MIN};
      program_coefs(cset);
      seq = '{PRICE_MIN, PRICE_MAX, PRICE_MIN, PRICE_MAX, price_type'(0), price_type'(0)};
      foreach (seq[i]) send_price(seq[i]);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         mode = phase % 4;
         for (int i = 0; i < NUM_REGS; i++) begin
            case (mode)
               0: cset[i] = COEF_RESET[i];
               // small detune of the stock filter keeps it mostly stable
               1: cset[i] = COEF_RESET[i] + coef_type'(int'($urandom_range(0, 2000)) - 1000);
               2: cset[i] = coef_type'($urandom);
               default: begin
                  case ($urandom_range(0, 3))
                     0: cset[i] = COEF_MAX;
                     1: cset[i] = COEF_MIN;
                     2: cset[i] = '0;
                     default: cset[i] = COEF_RESET[i];
                  endcase
               end
            endcase
         end
         program_coefs(cset);

         // every third phase runs without gaps on either side
         idle_on = (phase % 3) != 2;
         if (phase == 5) begin
            idle_on     = 1'b0;
            hold_cycles = 80;
         end

         walk = int'(price_type'($urandom));
         for (int n = 0; n < 125; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               // price series drifting in small steps, as a market feed would
               walk += int'($urandom_range(0, 2000)) - 1000;
               if (walk > int'(PRICE_MAX)) walk = int'(PRICE_MAX);
               if (walk < int'(PRICE_MIN)) walk = int'(PRICE_MIN);
               p = price_type'(walk);
            end else if (pick < 85) begin
               p = price_type'($urandom);
            end else begin
               case ($urandom_range(0, 4))
                  0: p = PRICE_MAX;
                  1: p = PRICE_MIN;
                  2: p = '0;
                  3: p = price_type'(-1);
                  default: p = price_type'(1);
               endcase
            end
            send_price(p);
         end
         // sender pauses here until every owed value has come back
         drain();
      end

      // leave the block on its stock coefficients for a last short run
      foreach (cset[i]) cset[i] = COEF_RESET[i];
      program_coefs(cset);
      idle_on = 1'b1;
      for (int n = 0; n < 20; n++) send_price(price_type'($urandom));
      drain();

      if (roofs.errors == 0 && roofs.depth() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog: a correct run needs well under a tenth of this
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
